// ===== hw/rtl/bmrsc_pkg.sv =====
`timescale 1ns / 1ps

package bmrsc_pkg;

  localparam int unsigned BitW     = 17;
  localparam int unsigned OpW      = 2;
  localparam int unsigned InTdataW = 40;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic split;
    logic clr_wr;
    logic rd;
    logic wr;
    logic next_word;
    logic cap_word;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic skip;
    logic last_word;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/bitmap_range_set_clear_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: start_bit, end_bit
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: read_word, range_error
//
// After reset the bitmap memory is swept to zero, word by word, with no item taken.
// A range item touching n words does a read-modify-write per word on the single
// memory port; a read fetches one word, and a rejected or empty item does none.
// One item is in work at a time; the next is taken once its result sits in the
// output register, which holds while m_axis_tready is low.
module bitmap_range_set_clear_core #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned WORDS     = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bmrsc_pkg::InTdataW-1:0]    s_axis_tdata,  // start_bit, end_bit
  input  logic [bmrsc_pkg::OpW-1:0]         s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((WORD_BITS + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata  // read_word, range_error
);

  localparam int unsigned OUT_W = ((WORD_BITS + 1 + 7) / 8) * 8;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BW    = bmrsc_pkg::BitW;

  bmrsc_pkg::cmd_t      cmd;
  bmrsc_pkg::sts_t      sts;
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] out_word;
  logic                 out_err;

  bmrsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmrsc_dpath #(
    .WORD_BITS (WORD_BITS),
    .WORDS     (WORDS),
    .AW        (AW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tuser),
    .start_i     (s_axis_tdata[BW-1:0]),
    .end_i       (s_axis_tdata[2*BW-1:BW]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_word_o  (out_word),
    .out_err_o   (out_err),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  bmrsc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = OUT_W'({out_err, out_word});

endmodule

// ===== hw/rtl/bmrsc_ram.sv =====
`timescale 1ns / 1ps

module bmrsc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bmrsc_ctrl.sv =====
`timescale 1ns / 1ps

module bmrsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmrsc_pkg::sts_t   sts_i,
  output bmrsc_pkg::cmd_t   cmd_o
);

  bmrsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmrsc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bmrsc_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = bmrsc_pkg::ST_IDLE;
        end
      end
      bmrsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bmrsc_pkg::ST_SPLIT;
        end
      end
      bmrsc_pkg::ST_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d     = sts_i.skip ? bmrsc_pkg::ST_RESP : bmrsc_pkg::ST_READ;
      end
      bmrsc_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = bmrsc_pkg::ST_WRITE;
      end
      bmrsc_pkg::ST_WRITE: begin
        if (sts_i.is_read) begin
          cmd_o.cap_word = 1'b1;
          state_d        = bmrsc_pkg::ST_RESP;
        end else begin
          cmd_o.wr = 1'b1;
          if (sts_i.last_word) begin
            state_d = bmrsc_pkg::ST_RESP;
          end else begin
            cmd_o.next_word = 1'b1;
            state_d         = bmrsc_pkg::ST_READ;
          end
        end
      end
      bmrsc_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d    = bmrsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmrsc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bmrsc_dpath.sv =====
`timescale 1ns / 1ps

module bmrsc_dpath #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned WORDS     = 1024,
  parameter int unsigned AW        = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bmrsc_pkg::cmd_t                cmd_i,
  output bmrsc_pkg::sts_t                sts_o,
  input  logic [bmrsc_pkg::OpW-1:0]      op_i,
  input  logic [bmrsc_pkg::BitW-1:0]     start_i,
  input  logic [bmrsc_pkg::BitW-1:0]     end_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [WORD_BITS-1:0]           out_word_o,
  output logic                           out_err_o,
  output logic                           ram_we_o,
  output logic                           ram_re_o,
  output logic [AW-1:0]                  ram_addr_o,
  output logic [WORD_BITS-1:0]           ram_wdata_o,
  input  logic [WORD_BITS-1:0]           ram_rdata_i
);

  localparam int unsigned BW       = bmrsc_pkg::BitW;
  localparam int unsigned OW       = $clog2(WORD_BITS + 1);
  localparam int unsigned DivShift = 24;
  localparam int unsigned RecipW   = DivShift - 2;
  localparam int unsigned ProdW    = BW + RecipW;
  localparam int unsigned QW       = ProdW - DivShift;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((1 << DivShift) + WORD_BITS - 1) / WORD_BITS);
  localparam logic [31:0] BitmapSize = 32'(WORDS * WORD_BITS);

  function automatic logic [WORD_BITS-1:0] low_ones(input logic [OW-1:0] n);
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (OW'(i) < n);
    end
    return m;
  endfunction

  logic [BW-1:0]        start_q;
  logic [BW-1:0]        end_m1_q;
  logic                 fill_q;
  logic                 read_q;
  logic                 skip_q;
  logic                 err_q;
  logic [ProdW-1:0]     prod_s_q;
  logic [ProdW-1:0]     prod_e_q;
  logic [AW-1:0]        w_q;
  logic [AW-1:0]        first_q;
  logic [AW-1:0]        last_q;
  logic [OW-1:0]        lo_q;
  logic [OW-1:0]        hi_q;
  logic [WORD_BITS-1:0] word_q;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] out_word_q;
  logic                 out_err_q;

  logic                 is_range;
  logic                 is_read;
  logic                 rng_err;
  logic                 rd_err;
  logic [BW-1:0]        end_m1;
  logic [QW-1:0]        q_s;
  logic [QW-1:0]        q_e;
  logic [BW-1:0]        rem_s;
  logic [OW-1:0]        lo_w;
  logic [OW-1:0]        hi_w;
  logic [WORD_BITS-1:0] mask;

  assign is_range = (op_i == bmrsc_pkg::OP_CLEAR) || (op_i == bmrsc_pkg::OP_FILL);
  assign is_read  = (op_i == bmrsc_pkg::OP_READ);
  assign rng_err  = (end_i < start_i) || ({15'd0, end_i} > BitmapSize);
  assign rd_err   = ({15'd0, start_i} >= 32'(WORDS));
  assign end_m1   = end_i - BW'(1);

  assign q_s   = prod_s_q[DivShift +: QW];
  assign q_e   = prod_e_q[DivShift +: QW];
  assign rem_s = start_q - BW'(BW'(q_s) * BW'(WORD_BITS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q  <= start_i;
      end_m1_q <= end_m1;
      fill_q   <= (op_i == bmrsc_pkg::OP_FILL);
      read_q   <= is_read;
      err_q    <= (is_range && rng_err) || (is_read && rd_err);
      skip_q   <= is_range ? (rng_err || (end_i == start_i)) : (!is_read || rd_err);
      prod_s_q <= ProdW'(start_i) * ProdW'(Recip);
      prod_e_q <= ProdW'(end_m1) * ProdW'(Recip);
      word_q   <= '0;
    end
    if (cmd_i.split && !read_q) begin
      first_q <= AW'(q_s);
      last_q  <= AW'(q_e);
      lo_q    <= OW'(rem_s);
      hi_q    <= OW'(end_m1_q - BW'(BW'(q_e) * BW'(WORD_BITS))) + OW'(1);
    end
    if (cmd_i.cap_word) begin
      word_q <= ram_rdata_i;
    end
    if (cmd_i.resp) begin
      out_word_q <= word_q;
      out_err_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        w_q <= (w_q == AW'(WORDS - 1)) ? '0 : w_q + AW'(1);
      end else if (cmd_i.load && is_read) begin
        w_q <= AW'(start_i);
      end else if (cmd_i.split && !read_q) begin
        w_q <= AW'(q_s);
      end else if (cmd_i.next_word) begin
        w_q <= w_q + AW'(1);
      end
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign lo_w = (w_q == first_q) ? lo_q : '0;
  assign hi_w = (w_q == last_q) ? hi_q : OW'(WORD_BITS);
  assign mask = low_ones(OW'(WORD_BITS) - lo_w) & ~low_ones(OW'(WORD_BITS) - hi_w);

  assign ram_addr_o  = w_q;
  assign ram_re_o    = cmd_i.rd;
  assign ram_we_o    = cmd_i.clr_wr || cmd_i.wr;
  assign ram_wdata_o = cmd_i.clr_wr ? '0 :
                       fill_q ? (ram_rdata_i | mask) : (ram_rdata_i & ~mask);

  assign sts_o.is_read   = read_q;
  assign sts_o.skip      = skip_q;
  assign sts_o.last_word = (w_q == last_q);
  assign sts_o.clr_last  = (w_q == AW'(WORDS - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_err_o   = out_err_q;

endmodule
